// ===== src/csi_pkg.sv =====
// ----------------------------------------------------------------------------
// Cone/sphere intersection test: shared definitions
// Register indexes, reset values, field widths and the cone setup bundle.
// ----------------------------------------------------------------------------
package csi_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;

    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int AXIS_W      = 16;
    localparam int SPAN_W      = 16;
    localparam int TRIG_W      = 17;
    localparam int INV_W       = 16;

    // Chunk size of the split multiplier.
    localparam int MUL_CHUNK = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_APEX     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAR_END  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPAN     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COS_SQ   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SIN_SQ   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_SINE = 3'd6;

    localparam logic [CFG_DATA_W-1:0] APEX_RESET     = '0;
    localparam logic [CFG_DATA_W-1:0] AXIS_RESET     = 48'd16384;
    localparam logic [CFG_DATA_W-1:0] FAR_END_RESET  = '0;
    localparam logic [SPAN_W-1:0]     SPAN_RESET     = '0;
    localparam logic [TRIG_W-1:0]     COS_SQ_RESET   = '0;
    localparam logic [TRIG_W-1:0]     SIN_SQ_RESET   = 17'd65536;
    localparam logic [INV_W-1:0]      INV_SINE_RESET = 16'd4096;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] apex_position;
        logic [CFG_DATA_W-1:0] axis_direction;
        logic [CFG_DATA_W-1:0] far_end_position;
        logic [SPAN_W-1:0]     axis_span;
        logic [TRIG_W-1:0]     cos_angle_squared;
        logic [TRIG_W-1:0]     sin_angle_squared;
        logic [INV_W-1:0]      inverse_sine;
    } cone_cfg_t;

endpackage

// ===== src/cone_sphere_intersection_test.sv =====
// ----------------------------------------------------------------------------
// Cone/sphere intersection test
// Decides per sphere whether it may touch the configured cone: a coarse
// reject around the cone end, the cone test with the apex pulled back by
// radius / sin, the region behind the apex, and a cutoff along the axis.
//
//   Channel   Handshake              Payload
//   config    cfg_we                 cfg_index, cfg_data
//   sphere    in_valid / in_ready    center_x, center_y, center_z, sphere_radius
//   result    out_valid / out_ready  hit
//
// Six register stages; a sphere's result is offered from the last of them,
// and one beat can be taken every cycle while the pipeline is not held.
// The whole pipeline advances together; it holds when the output register is
// full and out_ready is low, so in_ready is low only while a result waits
// and out_ready is low.
// The stage count is set by the two wide products, which go through the
// two-stage split multiplier.
// Reset clears the valid bits and loads the cone registers with their
// defaults.
// ----------------------------------------------------------------------------
module cone_sphere_intersection_test #(
    parameter int COORD_WIDTH = csi_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [csi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [COORD_WIDTH-1:0]   center_x,
    input  logic signed [COORD_WIDTH-1:0]   center_y,
    input  logic signed [COORD_WIDTH-1:0]   center_z,
    input  logic [COORD_WIDTH-2:0]          sphere_radius,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit
);
    import csi_pkg::*;

    localparam int NSTAGE = 6;

    localparam int TRIG_SHIFT = 12;
    localparam int AXIS_FRAC  = 14;
    localparam int PULL_SHIFT = 26;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int RW   = CW - 1;
    localparam int KW   = RW + INV_W;
    localparam int SW   = ((RW > SPAN_W) ? RW : SPAN_W) + 1;
    localparam int DDW  = 2 * DW;
    localparam int PW   = DW + AXIS_W + 1;
    localparam int AW2  = 2 * AXIS_W;
    localparam int QW   = AW2 + 1;
    localparam int KAW  = KW + AW2;
    localparam int KQW  = KW + 1 + QW;
    localparam int EW   = ((PW + PULL_SHIFT > KAW + 1) ? PW + PULL_SHIFT : KAW + 1) + 1;
    localparam int WW   = ((PW + PULL_SHIFT + 1 > KAW + 1) ? PW + PULL_SHIFT + 1 : KAW + 1) + 1;
    localparam int PSQW = 2 * PW;
    localparam int CDW  = DDW + TRIG_W;
    localparam int XW   = ((PSQW > CDW + TRIG_SHIFT) ? PSQW : CDW + TRIG_SHIFT) + 1;
    localparam int KQWW = KQW + WW;
    localparam int TW   = ((XW + 2 * PULL_SHIFT > KQWW) ? XW + 2 * PULL_SHIFT : KQWW) + 1;
    localparam int RSQW = 2 * RW;
    localparam int SSQW = 2 * SW;
    localparam int GSW  = (DDW > SSQW) ? DDW : SSQW;
    localparam int DRW  = (DDW > RSQW) ? DDW : RSQW;
    localparam int LW   = ((PW > SW + AXIS_FRAC + 1) ? PW : SW + AXIS_FRAC + 1) + 1;
    localparam int EXT  = (3 * CW > CFG_DATA_W) ? 3 * CW : CFG_DATA_W;

    typedef struct packed {
        logic near;
        logic e_pos;
        logic in_r;
        logic p_neg;
        logic p_cut;
    } test_flags_t;

    cone_cfg_t cfg;

    logic                   en;
    logic [NSTAGE-1:0]      valid_reg;

    logic [EXT-1:0]         apex_wide;
    logic [EXT-1:0]         far_wide;
    logic signed [CW-1:0]   cin     [3];
    logic signed [CW-1:0]   apex_c  [3];
    logic signed [CW-1:0]   far_c   [3];
    logic signed [AXIS_W-1:0] ax    [3];

    // stage 1
    logic signed [DW-1:0]   d_next  [3];
    logic signed [DW-1:0]   g_next  [3];
    logic signed [DW-1:0]   d1_reg  [3];
    logic signed [DW-1:0]   g1_reg  [3];
    logic [KW-1:0]          k_next;
    logic [KW-1:0]          k1_reg;
    logic [SW-1:0]          s_next;
    logic [SW-1:0]          s1_reg;
    logic [RW-1:0]          r1_reg;
    logic [AW2-1:0]         a_next;
    logic [AW2-1:0]         a1_reg;

    // stage 2
    logic [DDW-1:0]         dd_next;
    logic [DDW-1:0]         gg_next;
    logic signed [PW-1:0]   p_next;
    logic [KAW-1:0]         ka_next;
    logic signed [QW-1:0]   q_next;
    logic [RSQW-1:0]        rsq_next;
    logic [SSQW-1:0]        ssq_next;
    logic [DDW-1:0]         dd2_reg;
    logic [DDW-1:0]         gg2_reg;
    logic signed [PW-1:0]   p2_reg;
    logic [KAW-1:0]         ka2_reg;
    logic signed [QW-1:0]   q2_reg;
    logic [RSQW-1:0]        rsq2_reg;
    logic [SSQW-1:0]        ssq2_reg;
    logic [KW-1:0]          k2_reg;
    logic [SW-1:0]          s2_reg;

    // stage 3
    logic signed [EW-1:0]   e_val;
    logic signed [WW-1:0]   w_next;
    logic signed [KQW-1:0]  kq_next;
    logic [CDW-1:0]         cdd_next;
    logic [CDW-1:0]         sdd_next;
    test_flags_t            flags_next;
    logic signed [WW-1:0]   w3_reg;
    logic signed [KQW-1:0]  kq3_reg;
    logic [CDW-1:0]         cdd3_reg;
    logic [CDW-1:0]         sdd3_reg;
    test_flags_t            flags3_reg;

    // stage 4
    logic signed [PSQW-1:0] psq4;
    logic [CDW-1:0]         cdd4_reg;
    logic [CDW-1:0]         sdd4_reg;
    test_flags_t            flags4_reg;

    // stage 5
    logic signed [XW-1:0]   x_next;
    logic                   y_ok_next;
    logic signed [XW-1:0]   x5_reg;
    logic                   y_ok5_reg;
    test_flags_t            flags5_reg;
    logic signed [KQWW-1:0] kqw5;

    // stage 6
    logic signed [TW-1:0]   t_val;
    logic                   hit_next;
    logic                   hit_reg;

    csi_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    assign en       = !valid_reg[NSTAGE-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NSTAGE-2:0], in_valid};
        end
    end

    // Coordinate fields past the end of a 48-bit register read as zero bits.
    assign apex_wide = EXT'(cfg.apex_position);
    assign far_wide  = EXT'(cfg.far_end_position);

    assign cin[0] = center_x;
    assign cin[1] = center_y;
    assign cin[2] = center_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            apex_c[i] = $signed(apex_wide[CW*i +: CW]);
            far_c[i]  = $signed(far_wide[CW*i +: CW]);
            ax[i]     = $signed(cfg.axis_direction[AXIS_W*i +: AXIS_W]);
        end
    end

    // ---------------- stage 1: offsets, pull-back distance, axis norm -------
    always_comb
    begin
        a_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = DW'(cin[i]) - DW'(apex_c[i]);
            g_next[i] = DW'(cin[i]) - DW'(far_c[i]);
            a_next    = a_next + (AW2'(ax[i]) * AW2'(ax[i]));
        end
        k_next = KW'(sphere_radius) * KW'(cfg.inverse_sine);
        s_next = SW'(sphere_radius) + SW'(cfg.axis_span);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i] <= d_next[i];
                g1_reg[i] <= g_next[i];
            end
            k1_reg <= k_next;
            s1_reg <= s_next;
            r1_reg <= sphere_radius;
            a1_reg <= a_next;
        end
    end

    // ---------------- stage 2: squared lengths and axis projection ----------
    always_comb
    begin
        dd_next = '0;
        gg_next = '0;
        p_next  = '0;
        for (int i = 0; i < 3; i++)
        begin
            dd_next = dd_next + (DDW'(d1_reg[i]) * DDW'(d1_reg[i]));
            gg_next = gg_next + (DDW'(g1_reg[i]) * DDW'(g1_reg[i]));
            p_next  = p_next + (PW'(ax[i]) * PW'(d1_reg[i]));
        end
        ka_next  = KAW'(k1_reg) * KAW'(a1_reg);
        q_next   = $signed({1'b0, a1_reg})
                 - QW'($signed({1'b0, cfg.cos_angle_squared, {TRIG_SHIFT{1'b0}}}));
        rsq_next = RSQW'(r1_reg) * RSQW'(r1_reg);
        ssq_next = SSQW'(s1_reg) * SSQW'(s1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd2_reg  <= dd_next;
            gg2_reg  <= gg_next;
            p2_reg   <= p_next;
            ka2_reg  <= ka_next;
            q2_reg   <= q_next;
            rsq2_reg <= rsq_next;
            ssq2_reg <= ssq_next;
            k2_reg   <= k1_reg;
            s2_reg   <= s1_reg;
        end
    end

    // ---------------- stage 3: pulled-back apex terms and simple tests ------
    // With the apex pulled back along the axis, the projection is
    // E = P * 2^26 + k * A, and E^2 - 4096 * cos^2 * |D|^2 reduces to
    // 2^52 * (P^2 - 4096 * cos^2 * Dd) + k * Q * (P * 2^27 + k * A),
    // where Q = A - 4096 * cos^2. The bracketed factor of the second term is W below.
    always_comb
    begin
        e_val    = (EW'(p2_reg) <<< PULL_SHIFT) + EW'($signed({1'b0, ka2_reg}));
        w_next   = (WW'(p2_reg) <<< (PULL_SHIFT + 1)) + WW'($signed({1'b0, ka2_reg}));
        kq_next  = KQW'($signed({1'b0, k2_reg})) * KQW'(q2_reg);
        cdd_next = CDW'(cfg.cos_angle_squared) * CDW'(dd2_reg);
        sdd_next = CDW'(cfg.sin_angle_squared) * CDW'(dd2_reg);

        flags_next.near  = GSW'(gg2_reg) < GSW'(ssq2_reg);
        flags_next.e_pos = !e_val[EW-1] && (e_val != '0);
        flags_next.in_r  = DRW'(dd2_reg) <= DRW'(rsq2_reg);
        flags_next.p_neg = p2_reg[PW-1];
        flags_next.p_cut = LW'(p2_reg)
                         < LW'($signed({1'b0, s2_reg, {AXIS_FRAC{1'b0}}}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w3_reg     <= w_next;
            kq3_reg    <= kq_next;
            cdd3_reg   <= cdd_next;
            sdd3_reg   <= sdd_next;
            flags3_reg <= flags_next;
        end
    end

    // P^2 enters here and comes out at stage 4.
    csi_mul #(
        .AW (PW),
        .BW (PW)
    ) u_psq (
        .clk (clk),
        .en  (en),
        .a   (p2_reg),
        .b   (p2_reg),
        .p   (psq4)
    );

    // ---------------- stage 4: wide product k * Q * W in flight -------------
    csi_mul #(
        .AW (KQW),
        .BW (WW)
    ) u_kqw (
        .clk (clk),
        .en  (en),
        .a   (kq3_reg),
        .b   (w3_reg),
        .p   (kqw5)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cdd4_reg   <= cdd3_reg;
            sdd4_reg   <= sdd3_reg;
            flags4_reg <= flags3_reg;
        end
    end

    // ---------------- stage 5: angle terms against the projection -----------
    always_comb
    begin
        x_next    = XW'(psq4)
                  - XW'($signed({1'b0, cdd4_reg, {TRIG_SHIFT{1'b0}}}));
        y_ok_next = XW'(psq4)
                 >= XW'($signed({1'b0, sdd4_reg, {TRIG_SHIFT{1'b0}}}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x5_reg     <= x_next;
            y_ok5_reg  <= y_ok_next;
            flags5_reg <= flags4_reg;
        end
    end

    // ---------------- stage 6: cone test sign and final decision ------------
    always_comb
    begin
        t_val    = (TW'(x5_reg) <<< (2 * PULL_SHIFT)) + TW'(kqw5);
        hit_next = flags5_reg.near && flags5_reg.e_pos && !t_val[TW-1]
                && ((flags5_reg.p_neg && y_ok5_reg) ? flags5_reg.in_r
                                                    : flags5_reg.p_cut);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = valid_reg[NSTAGE-1];
    assign hit       = hit_reg;

endmodule

// ===== src/csi_cfg.sv =====
// ----------------------------------------------------------------------------
// Cone/sphere intersection test: cone setup registers
// Decodes register writes and holds the cone description.
// ----------------------------------------------------------------------------
module csi_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [csi_pkg::CFG_INDEX_W-1:0]  index,
    input  logic [csi_pkg::CFG_DATA_W-1:0]   data,
    output csi_pkg::cone_cfg_t               cfg
);
    import csi_pkg::*;

    logic [CFG_DATA_W-1:0] apex_reg;
    logic [CFG_DATA_W-1:0] axis_reg;
    logic [CFG_DATA_W-1:0] far_end_reg;
    logic [SPAN_W-1:0]     span_reg;
    logic [TRIG_W-1:0]     cos_sq_reg;
    logic [TRIG_W-1:0]     sin_sq_reg;
    logic [INV_W-1:0]      inv_sine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apex_reg     <= APEX_RESET;
            axis_reg     <= AXIS_RESET;
            far_end_reg  <= FAR_END_RESET;
            span_reg     <= SPAN_RESET;
            cos_sq_reg   <= COS_SQ_RESET;
            sin_sq_reg   <= SIN_SQ_RESET;
            inv_sine_reg <= INV_SINE_RESET;
        end
        else if (we)
        begin
            case (index)
                REG_APEX:     apex_reg     <= data;
                REG_AXIS:     axis_reg     <= data;
                REG_FAR_END:  far_end_reg  <= data;
                REG_SPAN:     span_reg     <= data[SPAN_W-1:0];
                REG_COS_SQ:   cos_sq_reg   <= data[TRIG_W-1:0];
                REG_SIN_SQ:   sin_sq_reg   <= data[TRIG_W-1:0];
                REG_INV_SINE: inv_sine_reg <= data[INV_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg.apex_position     = apex_reg;
    assign cfg.axis_direction    = axis_reg;
    assign cfg.far_end_position  = far_end_reg;
    assign cfg.axis_span         = span_reg;
    assign cfg.cos_angle_squared = cos_sq_reg;
    assign cfg.sin_angle_squared = sin_sq_reg;
    assign cfg.inverse_sine      = inv_sine_reg;

endmodule

// ===== src/csi_mul.sv =====
// ----------------------------------------------------------------------------
// Cone/sphere intersection test: split pipelined multiplier
// Signed product in two stages: partial products of the first operand with
// 16-bit chunks of the second, then a shifted sum.
// ----------------------------------------------------------------------------
module csi_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p
);
    import csi_pkg::*;

    localparam int NC  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BXW = NC * MUL_CHUNK;
    localparam int PPW = AW + MUL_CHUNK + 1;
    localparam int PRW = AW + BW;

    logic signed [BXW-1:0] b_ext;
    logic signed [PPW-1:0] pp_next [NC];
    logic signed [PPW-1:0] pp_reg  [NC];
    logic signed [PRW-1:0] p_next;
    logic signed [PRW-1:0] p_reg;

    assign b_ext = BXW'(b);

    // Lower chunks are unsigned; only the top chunk carries the sign.
    always_comb
    begin
        for (int j = 0; j < NC; j++)
        begin
            pp_next[j] = PPW'(a) * PPW'($signed({
                (j == NC - 1) ? b_ext[MUL_CHUNK*j + MUL_CHUNK - 1] : 1'b0,
                b_ext[MUL_CHUNK*j +: MUL_CHUNK]}));
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int j = 0; j < NC; j++)
        begin
            p_next = p_next + (PRW'(pp_reg[j]) <<< (MUL_CHUNK * j));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NC; j++)
            begin
                pp_reg[j] <= pp_next[j];
            end
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the cone/sphere intersection test
// Loads cone setups through the register port and streams sphere queries,
// with random idle cycles on both channels. Every hit bit is compared with
// an in-bench prediction of the fixed-point test on the same cone setup.
// ----------------------------------------------------------------------------
module tb_top;

    import csi_pkg::*;

    localparam int  CW               = COORD_WIDTH_DEFAULT;
    localparam int  CLK_PERIOD       = 10;
    localparam int  RESET_CYCLES     = 5;
    localparam int  PIPE_PAD         = 12;
    localparam int  HOLD_CYCLES      = 200;
    localparam int  STALL_LIMIT      = 3000;
    localparam int  CONE_COUNT       = 12;
    localparam int  SPHERES_PER_CONE = 125;
    localparam real PI               = 3.14159265358979;

    // Index 7 has no register behind it.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [CW-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [CW-1:0] COORD_MAX = 16'sh7FFF;
    localparam logic [CW-2:0]        RAD_MAX   = 15'h7FFF;
    localparam logic [CFG_DATA_W-1:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

    typedef logic signed [191:0] wide_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic signed [CW-1:0]   center_x      = '0;
    logic signed [CW-1:0]   center_y      = '0;
    logic signed [CW-1:0]   center_z      = '0;
    logic [CW-2:0]          sphere_radius = '0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic                   hit;

    // Cone registers as the block should hold them.
    logic [CFG_DATA_W-1:0] cone_apex_reg   = APEX_RESET;
    logic [CFG_DATA_W-1:0] cone_axis_reg   = AXIS_RESET;
    logic [CFG_DATA_W-1:0] cone_end_reg    = FAR_END_RESET;
    logic [SPAN_W-1:0]     cone_span_reg   = SPAN_RESET;
    logic [TRIG_W-1:0]     cone_cos_sq_reg = COS_SQ_RESET;
    logic [TRIG_W-1:0]     cone_sin_sq_reg = SIN_SQ_RESET;
    logic [INV_W-1:0]      cone_inv_reg    = INV_SINE_RESET;

    logic pending_hits[$];
    int   mismatch_count   = 0;
    int   hold_asked       = 0;
    bit   sender_gaps_on   = 1'b1;
    bit   receiver_stalls_on = 1'b1;

    // Shape of the last well-formed cone, used to aim spheres at it.
    real aim_apex [3];
    real aim_dir [3];
    real aim_len;
    real aim_tan;

    cone_sphere_intersection_test #(
        .COORD_WIDTH(CW)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .sphere_radius(sphere_radius),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic real rand01();
        return $urandom_range(0, 1000000) / 1000000.0;
    endfunction

    function automatic real rand_sym();
        return 2.0 * rand01() - 1.0;
    endfunction

    function automatic logic signed [CW-1:0] to_q6(real v);
        real scaled;
        scaled = v * 64.0;
        if (scaled > 32767.0)
            return COORD_MAX;
        if (scaled < -32768.0)
            return COORD_MIN;
        return 16'($rtoi(scaled));
    endfunction

    function automatic logic [CW-2:0] to_radius(real v);
        real scaled;
        scaled = v * 64.0;
        if (scaled > 32767.0)
            return RAD_MAX;
        if (scaled < 0.0)
            return '0;
        return 15'($rtoi(scaled));
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return COORD_MIN;
        if (pick == 1)
            return COORD_MAX;
        if (pick == 2)
            return '0;
        return 16'($urandom);
    endfunction

    function automatic logic [CW-2:0] rand_radius();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return RAD_MAX;
        return 15'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_reg();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return ALL_ONES;
        if (pick == 2)
            return 48'($urandom_range(0, 255));
        return 48'({$urandom, $urandom});
    endfunction

    // Exact hit decision for one sphere against the cone registers above.
    // All terms are carried at 192 bits, far more than any product needs.
    function automatic logic predict_cone_hit(logic signed [CW-1:0] cx, cy, cz,
                                              logic [CW-2:0] rad);
        wide_t ctr [3];
        wide_t apex [3];
        wide_t far_end [3];
        wide_t axis [3];
        wide_t d [3];
        wide_t rw, reach, pull, dist_sq, along, proj, cos_w, sin_w;
        wide_t unit12, unit14, unit26;
        logic  hit_bit;
        int    i;
        ctr[0] = cx;
        ctr[1] = cy;
        ctr[2] = cz;
        for (i = 0; i < 3; i++)
        begin
            apex[i]    = $signed(cone_apex_reg[CW*i +: CW]);
            far_end[i] = $signed(cone_end_reg[CW*i +: CW]);
            axis[i]    = $signed(cone_axis_reg[AXIS_W*i +: AXIS_W]);
        end
        unit12 = 4096;
        unit14 = 16384;
        unit26 = 1 << 26;
        rw     = $signed({1'b0, rad});
        reach  = $signed({1'b0, cone_span_reg}) + rw;
        pull   = rw * $signed({1'b0, cone_inv_reg});
        cos_w  = $signed({1'b0, cone_cos_sq_reg});
        sin_w  = $signed({1'b0, cone_sin_sq_reg});
        hit_bit = 1'b0;

        // Coarse reject: the sphere must reach into the sphere around the end.
        dist_sq = 0;
        for (i = 0; i < 3; i++)
        begin
            d[i] = ctr[i] - far_end[i];
            dist_sq += d[i] * d[i];
        end
        if (dist_sq < reach * reach)
        begin
            // Cone test with the apex pulled back by radius / sin.
            dist_sq = 0;
            along   = 0;
            for (i = 0; i < 3; i++)
                d[i] = (ctr[i] - apex[i]) * unit26 + pull * axis[i];
            for (i = 0; i < 3; i++)
            begin
                dist_sq += d[i] * d[i];
                along   += axis[i] * d[i];
            end
            if (along > 0 && along * along >= dist_sq * cos_w * unit12)
            begin
                dist_sq = 0;
                proj    = 0;
                for (i = 0; i < 3; i++)
                begin
                    d[i] = ctr[i] - apex[i];
                    dist_sq += d[i] * d[i];
                    proj    += axis[i] * d[i];
                end
                along = -proj;
                // Behind the real apex only the apex point itself can be hit.
                if (along > 0 && along * along >= dist_sq * sin_w * unit12)
                    hit_bit = (dist_sq <= rw * rw);
                else
                    hit_bit = (proj < reach * unit14);
            end
        end
        return hit_bit;
    endfunction

    // Offers one sphere and waits for its beat; valid stays high afterwards
    // so that a following sphere can go out on the very next cycle.
    task automatic send_sphere(input logic signed [CW-1:0] cx, cy, cz,
                               input logic [CW-2:0] rad);
        int gap;
        gap = sender_gaps_on ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        center_x      <= cx;
        center_y      <= cy;
        center_z      <= cz;
        sphere_radius <= rad;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_hits.push_back(predict_cone_hit(cx, cy, cz, rad));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_sel,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= value;
        case (reg_sel)
            REG_APEX:     cone_apex_reg   = value;
            REG_AXIS:     cone_axis_reg   = value;
            REG_FAR_END:  cone_end_reg    = value;
            REG_SPAN:     cone_span_reg   = value[SPAN_W-1:0];
            REG_COS_SQ:   cone_cos_sq_reg = value[TRIG_W-1:0];
            REG_SIN_SQ:   cone_sin_sq_reg = value[TRIG_W-1:0];
            REG_INV_SINE: cone_inv_reg    = value[INV_W-1:0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic close_config();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_cone(input logic [CFG_DATA_W-1:0] apex_v, axis_v, end_v,
                             input logic [CFG_DATA_W-1:0] span_v, cos_v, sin_v, inv_v);
        write_reg(REG_APEX, apex_v);
        write_reg(REG_AXIS, axis_v);
        write_reg(REG_FAR_END, end_v);
        write_reg(REG_SPAN, span_v);
        write_reg(REG_COS_SQ, cos_v);
        write_reg(REG_SIN_SQ, sin_v);
        write_reg(REG_INV_SINE, inv_v);
        close_config();
    endtask

    // Stops offering and lets every outstanding result beat come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (PIPE_PAD) @(posedge clk);
    endtask

    // Builds a consistent cone: unit axis, end point on the axis, matching
    // trig terms. Most angles are moderate, a few are very narrow or wide.
    task automatic load_random_cone();
        logic signed [CW-1:0]     apex_q [3];
        logic signed [CW-1:0]     end_q [3];
        logic signed [AXIS_W-1:0] axis_q [3];
        real norm, angle_deg, sin_a, cos_a, inv_val;
        int  shape, i, cos_q, sin_q, inv_q, span_q;
        norm = 0.0;
        while (norm < 0.1)
        begin
            for (i = 0; i < 3; i++)
                aim_dir[i] = rand_sym();
            norm = $sqrt(aim_dir[0] * aim_dir[0] + aim_dir[1] * aim_dir[1]
                         + aim_dir[2] * aim_dir[2]);
        end
        shape = $urandom_range(0, 9);
        if (shape == 0)
            angle_deg = 0.5;
        else if (shape == 1)
            angle_deg = 89.5;
        else
            angle_deg = 5.0 + 70.0 * rand01();
        aim_len = (shape == 2) ? 0.5 + 4.0 * rand01() : 5.0 + 195.0 * rand01();
        sin_a   = $sin(angle_deg * PI / 180.0);
        cos_a   = $cos(angle_deg * PI / 180.0);
        aim_tan = sin_a / cos_a;
        for (i = 0; i < 3; i++)
        begin
            aim_dir[i]  = aim_dir[i] / norm;
            aim_apex[i] = 150.0 * rand_sym();
            apex_q[i]   = to_q6(aim_apex[i]);
            axis_q[i]   = 16'($rtoi(aim_dir[i] * 16384.0));
            end_q[i]    = to_q6(aim_apex[i] + aim_dir[i] * aim_len);
        end
        span_q  = $rtoi(aim_len * 64.0);
        cos_q   = $rtoi(cos_a * cos_a * 65536.0 + 0.5);
        sin_q   = $rtoi(sin_a * sin_a * 65536.0 + 0.5);
        inv_val = 4096.0 / sin_a;
        inv_q   = (inv_val > 65535.0) ? 65535 : $rtoi(inv_val + 0.5);
        load_cone({apex_q[2], apex_q[1], apex_q[0]}, {axis_q[2], axis_q[1], axis_q[0]},
                  {end_q[2], end_q[1], end_q[0]}, 48'(span_q), 48'(cos_q),
                  48'(sin_q), 48'(inv_q));
    endtask

    // A sphere placed around the last random cone: along the axis from a bit
    // behind the apex to a bit past the end, off the axis by a random amount.
    task automatic send_near_sphere();
        real ctr [3];
        real t, spread, rad;
        int  i;
        t      = aim_len * (1.6 * rand01() - 0.3);
        spread = (((t < 0.0) ? -t : t) * aim_tan + 1.0) * 1.5 * rand01();
        for (i = 0; i < 3; i++)
            ctr[i] = aim_apex[i] + aim_dir[i] * t + spread * rand_sym();
        rad = rand01();
        rad = rad * rad * aim_len * 0.4;
        if ($urandom_range(0, 19) == 0)
            rad = 0.0;
        send_sphere(to_q6(ctr[0]), to_q6(ctr[1]), to_q6(ctr[2]), to_radius(rad));
    endtask

    task automatic send_noise_sphere();
        send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius());
    endtask

    task automatic test_reset_state();
        send_sphere(16'sd0, 16'sd0, 16'sd0, 15'd64);
        send_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 15'd0);
        send_sphere(COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX);
        send_sphere(COORD_MIN, COORD_MAX, 16'sd0, RAD_MAX);
        send_sphere(16'sd0, 16'sd0, 16'sd0, 15'd0);
        wait_drained();
        // A write to the spare index must leave the cone untouched.
        write_reg(REG_UNUSED, ALL_ONES);
        close_config();
        send_sphere(16'sd0, 16'sd0, 16'sd0, 15'd64);
        send_sphere(16'sd64, 16'sd0, 16'sd0, 15'd64);
        wait_drained();
    endtask

    // Cone along x from the origin, length 100.0, half angle 30 degrees.
    // Several spheres sit exactly on a boundary of one of the stages.
    task automatic test_hand_built_cone();
        load_cone(48'd0, AXIS_RESET, 48'd6400, 48'd6400, 48'd49152, 48'd16384, 48'd8192);
        send_sphere(16'sd3200, 16'sd0, 16'sd0, 15'd64);
        send_sphere(16'sd0, 16'sd3200, 16'sd0, 15'd64);
        send_sphere(-16'sd64, 16'sd0, 16'sd0, 15'd64);
        send_sphere(-16'sd64, 16'sd0, 16'sd0, 15'd63);
        send_sphere(16'sd6464, 16'sd0, 16'sd0, 15'd64);
        send_sphere(16'sd6463, 16'sd0, 16'sd0, 15'd64);
        send_sphere(16'sd6400, 16'sd6464, 16'sd0, 15'd64);
        send_sphere(16'sd6400, 16'sd6463, 16'sd0, 15'd64);
        send_sphere(16'sd3200, 16'sd1800, 16'sd0, 15'd0);
        wait_drained();
    endtask

    // Axis vectors that are not unit length and trig terms above one.
    task automatic test_odd_settings();
        load_cone(48'd0, {16'hC000, 16'h4000, 16'h4000}, 48'd0, ALL_ONES,
                  ALL_ONES, ALL_ONES, ALL_ONES);
        send_sphere(16'sd6400, 16'sd6400, -16'sd6400, 15'd3200);
        send_sphere(16'sd0, 16'sd0, 16'sd0, RAD_MAX);
        send_sphere(-16'sd6400, -16'sd6400, 16'sd6400, 15'd640);
        send_sphere(COORD_MAX, COORD_MAX, COORD_MIN, RAD_MAX);
        wait_drained();
        load_cone({16'h8000, 16'h7FFF, 16'h8000}, {16'h8000, 16'h8000, 16'h8000},
                  {16'h7FFF, 16'h8000, 16'h7FFF}, ALL_ONES, 48'd0, 48'd0, 48'd0);
        send_sphere(COORD_MIN, COORD_MAX, COORD_MIN, RAD_MAX);
        send_sphere(16'sd0, 16'sd0, 16'sd0, 15'd0);
        wait_drained();
    endtask

    task automatic test_random_cones();
        int n;
        for (n = 0; n < CONE_COUNT; n++)
        begin
            wait_drained();
            // Every fourth cone streams with no idle cycles on either side.
            sender_gaps_on     = (n % 4 != 3);
            receiver_stalls_on = (n % 4 != 3);
            load_random_cone();
            repeat (SPHERES_PER_CONE)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_near_sphere();
                else
                    send_noise_sphere();
            end
        end
        wait_drained();
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    task automatic test_random_registers();
        repeat (4)
        begin
            wait_drained();
            load_cone(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                      rand_reg(), rand_reg());
            write_reg(REG_UNUSED, rand_reg());
            close_config();
            repeat (50) send_noise_sphere();
        end
        wait_drained();
    endtask

    // The receiver refuses result beats for a long stretch while spheres keep
    // coming, so the pipeline fills and in_ready drops. Then a full-rate run.
    task automatic test_output_hold();
        wait_drained();
        load_random_cone();
        hold_asked++;
        repeat (60) send_near_sphere();
        wait_drained();
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        repeat (80) send_near_sphere();
        wait_drained();
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    initial
    begin : ready_driver
        int stall_left;
        int open_left;
        int hold_taken;
        stall_left = 0;
        open_left  = 0;
        hold_taken = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_taken)
            begin
                hold_taken = hold_asked;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (open_left > 0)
                    open_left--;
                else if (receiver_stalls_on)
                begin
                    stall_left = idle_len();
                    open_left  = $urandom_range(0, 8);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_hit
        logic want;
        if (out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat with no sphere pending, expected none, actual %b",
                         $time, hit);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit !== want)
                begin
                    mismatch_count++;
                    $display("%0t: hit mismatch, expected %b, actual %b", $time, want, hit);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat on either channel for %0d cycles", $time, quiet_cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_hand_built_cone();
        test_odd_settings();
        test_random_cones();
        test_random_registers();
        test_output_hold();
        wait_drained();
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
